FILE: hw/rtl/sobel_edge_magnitude_3x3_core_macros.svh
// assertion macros for the sobel edge magnitude core
// no dependencies; included by sem_fifo, the module that carries concurrent checks
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define SEM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true out of reset
`define SEM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SEM_ASSERT(lbl, clk, rst, prop, msg)
`define SEM_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: hw/rtl/sem_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the sobel edge magnitude core
// no dependencies; imported by every module of the block
package sem_pkg;

   // field widths
   localparam int PIXEL_W        = 8;
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;

   // default size limits
   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // register reset values
   localparam int FRAME_WIDTH_RESET  = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_IDX_FRAME_HEIGHT = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // saturated magnitude
   localparam logic [PIXEL_W-1:0] MAG_MAX = 8'd255;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               flush;
   } sem_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] edge_magnitude;
      logic               frame_last;
   } sem_rsp_type;

   // one 3x3 neighborhood, pix[column][row], column 0 left, row 0 top
   typedef struct packed {
      logic [2:0][2:0][PIXEL_W-1:0] pix;
      logic                         last;
   } sem_win_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sem_fifo_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_GRAD,
      BK_SQUARE,
      BK_ROOT,
      BK_DONE
   } sem_back_state_type;

   // limit a register value to 1..hi
   function automatic int unsigned sem_clamp(input int unsigned v, input int unsigned hi);
      int unsigned r;
      r = v;
      if (r < 1) r = 1;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

FILE: hw/rtl/sem_csr.sv
`timescale 1ns / 1ps
// configuration registers: frame width and height, clamped sizes and pixel total
// depends on sem_pkg
module sem_csr #(
   parameter int MAX_WIDTH  = sem_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sem_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sem_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [sem_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [sem_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0]        eff_width,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+2)-1:0] total_pixels,
   output logic                                  restart
);
   import sem_pkg::*;

   localparam int EW_W  = $clog2(MAX_WIDTH+1);
   localparam int EH_W  = $clog2(MAX_HEIGHT+1);
   localparam int POS_W = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+2);
   localparam int unsigned EW_RESET = sem_clamp(FRAME_WIDTH_RESET, MAX_WIDTH);
   localparam int unsigned EH_RESET = sem_clamp(FRAME_HEIGHT_RESET, MAX_HEIGHT);
   localparam int unsigned TOTAL_RESET = EW_RESET * EH_RESET;

   logic [FRAME_WIDTH_W-1:0]  width_ff,  width_in;
   logic [FRAME_HEIGHT_W-1:0] height_ff, height_in;
   logic [EW_W-1:0]           eff_w_ff,  eff_w_in;
   logic [EH_W-1:0]           eff_h_ff,  eff_h_in;
   logic [POS_W-1:0]          total_ff,  total_in;
   logic                      wr;
   logic [EW_W-1:0]           new_w;
   logic [EH_W-1:0]           new_h;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign new_w = EW_W'(sem_clamp(int'(csr_pwdata[FRAME_WIDTH_W-1:0]), MAX_WIDTH));
   assign new_h = EH_W'(sem_clamp(int'(csr_pwdata[FRAME_HEIGHT_W-1:0]), MAX_HEIGHT));

   // register write decode; the pixel total is refreshed with the write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      eff_w_in  = eff_w_ff;
      eff_h_in  = eff_h_ff;
      total_in  = total_ff;
      if (wr) begin
         unique case (csr_paddr[2])
            CSR_IDX_FRAME_WIDTH: begin
               width_in = csr_pwdata[FRAME_WIDTH_W-1:0];
               eff_w_in = new_w;
               total_in = POS_W'(POS_W'(new_w) * POS_W'(eff_h_ff));
            end
            CSR_IDX_FRAME_HEIGHT: begin
               height_in = csr_pwdata[FRAME_HEIGHT_W-1:0];
               eff_h_in  = new_h;
               total_in  = POS_W'(POS_W'(eff_w_ff) * POS_W'(new_h));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_W'(FRAME_WIDTH_RESET);
         height_ff <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET);
         eff_w_ff  <= EW_W'(EW_RESET);
         eff_h_ff  <= EH_W'(EH_RESET);
         total_ff  <= POS_W'(TOTAL_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         eff_w_ff  <= eff_w_in;
         eff_h_ff  <= eff_h_in;
         total_ff  <= total_in;
      end
   end

   // read back
   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IDX_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
      endcase
   end

   assign eff_width    = eff_w_ff;
   assign total_pixels = total_ff;
   assign restart      = wr;

endmodule

FILE: hw/rtl/sem_front.sv
`timescale 1ns / 1ps
// front end: frame position counters, line store memory and 3x3 window;
// classifies each input and pushes one neighborhood per result; depends on sem_pkg
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sem_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sem_pkg::sem_req_type                  req_data,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]        eff_width,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+2)-1:0] total_pixels,
   input  logic                                  restart,
   output logic                                  push,
   output sem_pkg::sem_win_type                  push_data,
   input  sem_pkg::sem_fifo_status_type          q_status
);
   import sem_pkg::*;

   localparam int EW_W  = $clog2(MAX_WIDTH+1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int POS_W = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+2);
   localparam int LS_W  = 2 * PIXEL_W;

   // position state
   logic [COL_W-1:0] col_ff,    col_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [POS_W-1:0] outcnt_ff, outcnt_in;
   logic             row_ge1_ff, row_ge1_in;
   logic             row_ge2_ff, row_ge2_in;

   // second stage
   logic               f1_valid_ff, f1_valid_in;
   logic [COL_W-1:0]   f1_col_ff;
   logic [PIXEL_W-1:0] f1_v_ff;
   logic               f1_emit_ff, f1_last_ff, f1_col0_ff, f1_left_ok_ff;
   logic               f1_row_ge1_ff, f1_row_ge2_ff;
   logic               f1_byp_ff;
   logic [LS_W-1:0]    f1_byp_data_ff;
   logic [LS_W-1:0]    rd_ff;

   // line stores: upper line in the high byte, lower line in the low byte
   logic [LS_W-1:0] line_mem [MAX_WIDTH];

   logic [2:0][2:0][PIXEL_W-1:0] win_ff, win_in;

   logic               accept, in_frame, ignore, take, emit, last, wrap;
   logic [PIXEL_W-1:0] v;
   logic               f1_adv;
   logic [LS_W-1:0]    rd_word, wdata;
   logic [2:0][PIXEL_W-1:0] incoming;

   assign req_stall = f1_valid_ff && f1_emit_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign in_frame  = pos_ff < total_pixels;
   assign ignore    = req_data.flush && in_frame;
   assign take      = accept && !ignore;
   assign emit      = (pos_ff >= POS_W'(eff_width) + POS_W'(1)) && (outcnt_ff < total_pixels);
   assign last      = (outcnt_ff + POS_W'(1)) >= total_pixels;
   assign wrap      = (EW_W'(col_ff) + EW_W'(1)) >= eff_width;
   assign v         = (in_frame && !req_data.flush) ? req_data.pixel_value : '0;

   // frame position counters
   always_comb begin
      col_in     = col_ff;
      pos_in     = pos_ff;
      outcnt_in  = outcnt_ff;
      row_ge1_in = row_ge1_ff;
      row_ge2_in = row_ge2_ff;
      if (restart || (take && emit && last)) begin
         col_in     = '0;
         pos_in     = '0;
         outcnt_in  = '0;
         row_ge1_in = 1'b0;
         row_ge2_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (emit) outcnt_in = outcnt_ff + POS_W'(1);
         if (wrap) begin
            col_in     = '0;
            row_ge2_in = row_ge1_ff;
            row_ge1_in = 1'b1;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         pos_ff     <= '0;
         outcnt_ff  <= '0;
         row_ge1_ff <= 1'b0;
         row_ge2_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         pos_ff     <= pos_in;
         outcnt_ff  <= outcnt_in;
         row_ge1_ff <= row_ge1_in;
         row_ge2_ff <= row_ge2_in;
      end
   end

   // second stage handshake
   assign f1_adv = f1_valid_ff && !(f1_emit_ff && q_status.full);

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (take) f1_valid_in = 1'b1;
      else if (f1_adv) f1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) f1_valid_ff <= 1'b0;
      else f1_valid_ff <= f1_valid_in;
   end

   // item state carried into the second stage
   always_ff @(posedge clock) begin
      if (take) begin
         f1_col_ff      <= col_ff;
         f1_v_ff        <= v;
         f1_emit_ff     <= emit;
         f1_last_ff     <= last;
         f1_col0_ff     <= (col_ff == '0);
         f1_left_ok_ff  <= (col_ff == '0) ? (eff_width >= EW_W'(2)) : (col_ff >= COL_W'(2));
         f1_row_ge1_ff  <= row_ge1_ff;
         f1_row_ge2_ff  <= row_ge2_ff;
         // same column written in this cycle (one pixel per row)
         f1_byp_ff      <= f1_valid_ff && (f1_col_ff == col_ff);
         f1_byp_data_ff <= wdata;
      end
   end

   // line store memory, registered read
   always_ff @(posedge clock) begin
      if (take) rd_ff <= line_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (f1_adv) line_mem[f1_col_ff] <= wdata;
   end

   assign rd_word = f1_byp_ff ? f1_byp_data_ff : rd_ff;
   assign wdata   = {rd_word[PIXEL_W-1:0], f1_v_ff};

   // new right column of the window, rows above the frame read as zero
   assign incoming[0] = f1_row_ge2_ff ? rd_word[LS_W-1:PIXEL_W] : '0;
   assign incoming[1] = f1_row_ge1_ff ? rd_word[PIXEL_W-1:0] : '0;
   assign incoming[2] = f1_v_ff;

   // window shift
   always_comb begin
      win_in = win_ff;
      if (f1_adv) begin
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = incoming;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) win_ff <= '0;
      else win_ff <= win_in;
   end

   // neighborhood for the result: center is the column before the new one
   always_comb begin
      push_data.pix[0] = f1_left_ok_ff ? win_ff[1] : '0;
      push_data.pix[1] = win_ff[2];
      push_data.pix[2] = f1_col0_ff ? '0 : incoming;
      push_data.last   = f1_last_ff;
   end

   assign push = f1_adv && f1_emit_ff;

endmodule

FILE: hw/rtl/sem_fifo.sv
`timescale 1ns / 1ps
// short queue of neighborhoods between front and back
// depends on sem_pkg and the core assertion macros
`include "sobel_edge_magnitude_3x3_core_macros.svh"
module sem_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sem_pkg::sem_win_type         push_data,
   input  logic                         pop,
   output sem_pkg::sem_win_type         head,
   output sem_pkg::sem_fifo_status_type status
);
   import sem_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

   sem_win_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   // queue contract between front and back
   `SEM_ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full, "push into full queue")
   `SEM_ASSERT_NEVER(a_no_underflow, clock, reset, pop && status.empty, "pop from empty queue")
   `SEM_ASSERT(a_empty_ptrs, clock, reset, !status.empty || (wr_ptr_ff == rd_ptr_ff), "empty queue with pointers apart")

endmodule

FILE: hw/rtl/sem_back.sv
`timescale 1ns / 1ps
// back end: sobel gradients, squared sum, bit-serial square root, result register
// depends on sem_pkg
module sem_back (
   input  logic                         clock,
   input  logic                         reset,
   input  sem_pkg::sem_fifo_status_type q_status,
   input  sem_pkg::sem_win_type         q_head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sem_pkg::sem_rsp_type         rsp_data
);
   import sem_pkg::*;

   localparam int SUM_W = PIXEL_W + 2;
   localparam int SQ_W  = 2 * PIXEL_W;
   localparam int BIT_W = $clog2(PIXEL_W);

   sem_back_state_type state_ff, state_in;

   sem_win_type        win_ff;
   logic [SUM_W-1:0]   gx_ff, gy_ff;
   logic [SQ_W:0]      s_ff;
   logic               sat_ff;
   logic [PIXEL_W-1:0] root_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   sem_rsp_type        rsp_ff;

   logic               load_rsp;
   logic [SUM_W-1:0]   px, nx, py, ny;
   logic [SQ_W-1:0]    sq_x, sq_y, tt;
   logic [PIXEL_W-1:0] t;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = BK_GRAD;
            end
         end
         BK_GRAD:   state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_ROOT;
         BK_ROOT: begin
            if (bit_ff == '0) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // weighted column and row sums of the neighborhood
   function automatic logic [SUM_W-1:0] wsum(input logic [PIXEL_W-1:0] a,
                                             input logic [PIXEL_W-1:0] b,
                                             input logic [PIXEL_W-1:0] c);
      return SUM_W'(a) + {1'b0, b, 1'b0} + SUM_W'(c);
   endfunction

   assign px = wsum(win_ff.pix[2][0], win_ff.pix[2][1], win_ff.pix[2][2]);
   assign nx = wsum(win_ff.pix[0][0], win_ff.pix[0][1], win_ff.pix[0][2]);
   assign py = wsum(win_ff.pix[0][2], win_ff.pix[1][2], win_ff.pix[2][2]);
   assign ny = wsum(win_ff.pix[0][0], win_ff.pix[1][0], win_ff.pix[2][0]);

   // squares of the low bytes; larger gradients saturate anyway
   assign sq_x = SQ_W'(gx_ff[PIXEL_W-1:0]) * SQ_W'(gx_ff[PIXEL_W-1:0]);
   assign sq_y = SQ_W'(gy_ff[PIXEL_W-1:0]) * SQ_W'(gy_ff[PIXEL_W-1:0]);

   // trial root bit
   assign t  = root_ff | (PIXEL_W'(1) << bit_ff);
   assign tt = SQ_W'(t) * SQ_W'(t);

   // datapath registers
   always_ff @(posedge clock) begin
      if (pop) win_ff <= q_head;
      if (state_ff == BK_GRAD) begin
         gx_ff <= (px >= nx) ? px - nx : nx - px;
         gy_ff <= (py >= ny) ? py - ny : ny - py;
      end
      if (state_ff == BK_SQUARE) begin
         s_ff    <= (SQ_W+1)'(sq_x) + (SQ_W+1)'(sq_y);
         sat_ff  <= (gx_ff[SUM_W-1:PIXEL_W] != '0) || (gy_ff[SUM_W-1:PIXEL_W] != '0);
         root_ff <= '0;
         bit_ff  <= BIT_W'(PIXEL_W-1);
      end
      if (state_ff == BK_ROOT) begin
         if ((SQ_W+1)'(tt) <= s_ff) root_ff <= t;
         bit_ff <= bit_ff - BIT_W'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.edge_magnitude <= (sat_ff || s_ff[SQ_W]) ? MAG_MAX : root_ff;
         rsp_ff.frame_last     <= win_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hw/rtl/sobel_edge_magnitude_3x3_core.sv
`timescale 1ns / 1ps
// sobel 3x3 edge magnitude, streaming; depends on sem_pkg and all sem_ modules
// result path: the input transfer that completes a pixel's lower neighbors, frame_width + 1
// items after the pixel itself, goes through the queue, the back and the result register
// throughput: one item per cycle at the front until the queue fills; the back's 8-step
// square root handles one result at a time, with a 4-entry queue absorbing bursts
// reset: synchronous; counters and window cleared, size back to 640 x 480, line memory kept
module sobel_edge_magnitude_3x3_core #(
   parameter int MAX_WIDTH  = sem_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sem_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sem_pkg::sem_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sem_pkg::sem_rsp_type           rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sem_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sem_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sem_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sem_pkg::*;

   localparam int EW_W  = $clog2(MAX_WIDTH+1);
   localparam int POS_W = $clog2(MAX_WIDTH*MAX_HEIGHT+MAX_WIDTH+2);

   logic [EW_W-1:0]     eff_width;
   logic [POS_W-1:0]    total_pixels;
   logic                restart;
   logic                push, pop;
   sem_win_type         push_data, q_head;
   sem_fifo_status_type q_status;

   // configuration registers
   sem_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .eff_width    (eff_width),
      .total_pixels (total_pixels),
      .restart      (restart)
   );

   // input side: counters, line stores, window
   sem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .eff_width    (eff_width),
      .total_pixels (total_pixels),
      .restart      (restart),
      .push         (push),
      .push_data    (push_data),
      .q_status     (q_status)
   );

   // neighborhood queue
   sem_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (q_head),
      .status    (q_status)
   );

   // magnitude unit and result register
   sem_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
